/* rtl/lome_pkg.sv */
// lome_pkg: types, codes and book-size constants of the order matching engine.
// Depends on nothing; every rtl file imports it.
`timescale 1ns / 1ps
package lome_pkg;

  localparam int BookEntriesDefault = 32;

  typedef enum logic [1:0] {
    OP_LIMIT  = 2'd0,
    OP_MARKET = 2'd1,
    OP_CANCEL = 2'd2,
    OP_MODIFY = 2'd3
  } opcode_t;

  typedef enum logic [1:0] {
    TIF_GTC = 2'd0,
    TIF_IOC = 2'd1,
    TIF_FOK = 2'd2,
    TIF_BAD = 2'd3
  } tif_t;

  typedef enum logic [2:0] {
    ST_RESTING   = 3'd0,
    ST_FILLED    = 3'd1,
    ST_PARTIAL   = 3'd2,
    ST_CANCELLED = 3'd3,
    ST_REJECTED  = 3'd4,
    ST_MODIFIED  = 3'd5
  } status_t;

  typedef enum logic [3:0] {
    RS_NONE      = 4'd0,
    RS_INVALID   = 4'd1,
    RS_DUPLICATE = 4'd2,
    RS_QTY       = 4'd3,
    RS_FOK       = 4'd4,
    RS_LIQUIDITY = 4'd5,
    RS_STP       = 4'd6,
    RS_FULL      = 4'd7,
    RS_ID        = 4'd8,
    RS_NOTFOUND  = 4'd9,
    RS_NOCHANGE  = 4'd10,
    RS_PRICE     = 4'd11,
    RS_TYPE      = 4'd12
  } reason_t;

  localparam logic KIND_TRADE  = 1'b0;
  localparam logic KIND_REPORT = 1'b1;

  typedef struct packed {
    logic [1:0]         opcode;
    logic [31:0]        order_id;
    logic [15:0]        client_id;
    logic               side;
    logic signed [31:0] price;
    logic [31:0]        quantity;
    logic [1:0]         time_in_force;
  } cmd_word_t;

  typedef struct packed {
    logic        record_kind;
    logic [31:0] report_order_id;
    logic [31:0] other_order_id;
    logic [15:0] other_client_id;
    logic [30:0] trade_price;
    logic [31:0] trade_quantity;
    logic [31:0] trade_number;
    logic [2:0]  status;
    logic [3:0]  reject_reason;
    logic [31:0] filled_quantity;
    logic [31:0] remaining_quantity;
    logic        last;
  } rec_word_t;

  // one stored order
  typedef struct packed {
    logic [31:0] order_id;
    logic [15:0] client;
    logic        side;
    logic [30:0] price;
    logic [31:0] quantity;
    logic [31:0] arrival_seq;
  } entry_t;

  // request from the sequencer to the book memory
  typedef struct packed {
    logic rd;
    logic wr;
    logic set_valid;
    logic clr_valid;
  } mem_req_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_CHECK,
    S_SCAN_RD,
    S_SCAN,
    S_SCAN_END,
    S_DECIDE,
    S_TRADE_RD,
    S_TRADE_WAIT,
    S_TRADE_OUT,
    S_REST,
    S_REPORT,
    S_DONE
  } fsm_t;

  typedef enum logic [1:0] {
    SC_FIND   = 2'd0,   // look up id, free slot
    SC_MATCH  = 2'd1,   // best eligible entry and eligible sum
    SC_CROSS  = 2'd2    // best unfiltered entry
  } scan_t;

endpackage

/* rtl/lome_book.sv */
// lome_book: storage of resting orders, one synchronous memory plus valid bits.
// Depends on lome_pkg.
`timescale 1ns / 1ps
module lome_book
  import lome_pkg::*;
#(
  parameter int BookEntries = BookEntriesDefault,
  localparam int AW = $clog2(BookEntries)
) (
  input  logic                   clk,
  input  logic                   rst,
  input  mem_req_t               req,
  input  logic [AW-1:0]          rd_addr,
  input  logic [AW-1:0]          wr_addr,
  input  entry_t                 wr_data,
  output entry_t                 rd_data,
  output logic [BookEntries-1:0] valid
);

  entry_t mem [BookEntries];

  always_ff @(posedge clk) begin
    if (req.wr) begin
      mem[wr_addr] <= wr_data;
    end
    if (req.rd) begin
      rd_data <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else begin
      if (req.clr_valid) valid[wr_addr] <= 1'b0;
      if (req.set_valid) valid[wr_addr] <= 1'b1;
    end
  end

endmodule

/* rtl/lome_out.sv */
// lome_out: output register stage that holds a result word until taken.
// Depends on lome_pkg.
`timescale 1ns / 1ps
module lome_out
  import lome_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  input  rec_word_t push_data,
  output logic      full,
  output logic      out_valid,
  input  logic      out_ready,
  output rec_word_t out_data
);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (push) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push) out_data <= push_data;
  end

  // push only when empty or draining this cycle
  assign full = out_valid && !out_ready;

endmodule

/* rtl/limit_order_matching_engine.sv */
// limit_order_matching_engine: price-time priority matcher over a bounded book.
// A book pass: read issue, then one data read per book entry, then the decide state.
// A resting limit order runs find, match and cross passes; each fill adds the trade read,
// wait and output states plus one more match pass, a crossing modify one more pass; a
// reject at check goes straight to the report. Output stalls hold the trade and report states.
// Throughput: one command in work at a time. Reset: synchronous rst empties the book
// (valid bits) and zeroes both counters. Depends on lome_pkg, lome_book, lome_out.
`timescale 1ns / 1ps
module limit_order_matching_engine
  import lome_pkg::*;
#(
  parameter int BookEntries = BookEntriesDefault,
  localparam int AW = $clog2(BookEntries)
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  cmd_word_t in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output rec_word_t out_data
);

  fsm_t state, state_next;

  // command in work
  cmd_word_t   cmd;
  logic [31:0] oid;         // order id being worked
  logic [15:0] cli;
  logic        sd;
  logic        mkt;         // match without price limit
  logic signed [32:0] px;   // working limit price
  logic [31:0] qty;         // remaining quantity to fill
  logic [31:0] filled;
  logic [1:0]  tif;
  logic        is_mod;      // modify re-entry in progress

  logic [31:0] arrival_counter;
  logic [31:0] trade_counter;

  // scan registers
  scan_t       scan;
  logic [AW:0] idx;         // read address issued
  logic [AW:0] cidx;        // address of data now on rd_data
  logic        found;
  logic [AW-1:0] found_slot;
  logic        free_ok;
  logic [AW-1:0] free_slot;
  logic        best_ok;
  logic [AW-1:0] best_slot;
  logic [30:0] best_price;
  logic [31:0] best_seq;
  logic [32:0] elig_sum;    // saturates at bit 32
  logic        any_opp;     // any opposite entry exists
  logic        fok_checked;

  entry_t      hit;         // entry read for trade, find or modify
  logic [2:0]  rep_status;
  logic [3:0]  rep_reason;
  logic [31:0] rep_remaining;

  logic [2:0]  rep_status_n;
  logic [3:0]  rep_reason_n;
  logic [31:0] rep_rem_n;

  // memory port
  mem_req_t      req;
  logic [AW-1:0] rd_addr, wr_addr;
  entry_t        wr_data, rd_data;
  logic [BookEntries-1:0] valid;

  lome_book #(.BookEntries(BookEntries)) u_book (
    .clk, .rst, .req, .rd_addr, .wr_addr, .wr_data, .rd_data, .valid
  );

  logic      push, full;
  rec_word_t push_data;

  lome_out u_out (
    .clk, .rst, .push, .push_data, .full, .out_valid, .out_ready, .out_data
  );

  // take a word only when idle and out of reset
  assign in_ready = (state == S_IDLE) && !rst;

  // eligibility of the entry now on rd_data
  logic [AW-1:0] cslot;
  logic          cval, opp, stp_skip, px_ok, elig, better_e, better_u;
  assign cslot    = cidx[AW-1:0];
  assign cval     = valid[cslot];
  assign opp      = cval && (rd_data.side != sd);
  assign stp_skip = (cli != 16'd0) && (rd_data.client == cli);
  assign px_ok    = mkt || (sd == 1'b0 ? $signed({2'b00, rd_data.price}) <= px
                                        : $signed({2'b00, rd_data.price}) >= px);
  assign elig     = opp && !stp_skip && px_ok;
  always_comb begin
    if (!best_ok) better_e = 1'b1;
    else if (rd_data.price != best_price)
      better_e = sd == 1'b0 ? rd_data.price < best_price : rd_data.price > best_price;
    else better_e = rd_data.arrival_seq < best_seq;
  end
  assign better_u = better_e;

  logic [31:0] fill_q;
  assign fill_q = (hit.quantity < qty) ? hit.quantity : qty;

  logic crosses;
  assign crosses = best_ok && (sd == 1'b0 ? px >= $signed({2'b00, best_price})
                                          : px <= $signed({2'b00, best_price}));

  // scan bookkeeping
  always_ff @(posedge clk) begin
    if (state == S_SCAN_RD) begin
      cidx <= idx;
    end else if (state == S_SCAN) begin
      cidx <= idx;
      if (cidx < AW'(0) + (AW+1)'(BookEntries)) begin
        // track the lowest free slot on every pass, so a rest sees the book as it is now
        if (!cval && !free_ok) begin
          free_ok <= 1'b1;
          free_slot <= cslot;
        end
        unique case (scan)
          SC_FIND: begin
            if (cval && rd_data.order_id == oid && !found) begin
              found <= 1'b1;
              found_slot <= cslot;
              hit <= rd_data;
            end
          end
          SC_MATCH: begin
            if (opp) any_opp <= 1'b1;
            if (elig) begin
              if (!elig_sum[32]) elig_sum <= elig_sum + {1'b0, rd_data.quantity};
              if (better_e) begin
                best_ok <= 1'b1; best_slot <= cslot;
                best_price <= rd_data.price; best_seq <= rd_data.arrival_seq;
              end
            end
          end
          default: begin
            if (opp && better_u) begin
              best_ok <= 1'b1; best_slot <= cslot;
              best_price <= rd_data.price; best_seq <= rd_data.arrival_seq;
            end
          end
        endcase
      end
    end
    if (state == S_IDLE || state == S_SCAN_END) begin
      // nothing
    end
    if (state_next == S_SCAN_RD && state != S_SCAN_RD) begin
      found <= 1'b0; free_ok <= 1'b0; best_ok <= 1'b0;
      elig_sum <= '0; any_opp <= 1'b0;
    end
    if (state == S_TRADE_WAIT) hit <= rd_data;
  end

  // scan index
  always_ff @(posedge clk) begin
    if (state_next == S_SCAN_RD && state != S_SCAN_RD) idx <= '0;
    else if ((state == S_SCAN_RD || state == S_SCAN) && idx < (AW+1)'(BookEntries))
      idx <= idx + 1'b1;
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end

  logic scan_done;
  assign scan_done = (state == S_SCAN) && (cidx == (AW+1)'(BookEntries - 1));

  // arrival and trade counters, cleared by rst
  always_ff @(posedge clk) begin
    if (rst) begin
      arrival_counter <= '0;
      trade_counter <= '0;
    end else begin
      if (state == S_TRADE_OUT && !full) trade_counter <= trade_counter + 1'b1;
      // advance the arrival count only when an order actually rests
      if (state == S_REST && free_ok) arrival_counter <= arrival_counter + 1'b1;
    end
  end

  // control of the command flow
  logic        start_scan;
  scan_t       scan_sel;
  always_ff @(posedge clk) begin
    if (state == S_IDLE && in_valid) begin
      cmd <= in_data;
      oid <= in_data.order_id;
      cli <= in_data.client_id;
      sd <= in_data.side;
      px <= {in_data.price[31], in_data.price};
      qty <= in_data.quantity;
      tif <= in_data.time_in_force;
      mkt <= (in_data.opcode == OP_MARKET);
      filled <= '0;
      is_mod <= 1'b0;
      fok_checked <= 1'b0;
    end
    if (start_scan) scan <= scan_sel;
    if (state == S_TRADE_OUT && !full) begin
      qty <= qty - fill_q;
      filled <= filled + fill_q;
    end
    if (state == S_DECIDE) begin
      if (scan == SC_MATCH) fok_checked <= 1'b1;
      if (scan == SC_FIND && cmd.opcode == OP_MODIFY && found) begin
        is_mod <= 1'b1;
        cli <= hit.client;
        sd <= hit.side;
        if (px <= 0 || px[30:0] == hit.price) px <= {2'b00, hit.price};
        qty <= (cmd.quantity != 0) ? cmd.quantity : hit.quantity;
        tif <= TIF_GTC;
      end
    end
    if (state == S_CHECK || state == S_DECIDE || state == S_TRADE_OUT ||
        state == S_REST) begin
      rep_status <= rep_status_n;
      rep_reason <= rep_reason_n;
      rep_remaining <= rep_rem_n;
    end
  end

  // final status of a limit order (also used by a crossing modify)
  function automatic logic [2:0] mod_st(input logic m, input logic [2:0] s);
    if (m && s != ST_REJECTED && s != ST_FILLED) return ST_MODIFIED;
    return s;
  endfunction

  logic chg;
  assign chg = (px > 0 && px[30:0] != hit.price && !px[32]) ||
               (cmd.quantity != 0 && cmd.quantity != hit.quantity);

  always_comb begin
    state_next = state;
    req = '0;
    rd_addr = idx[AW-1:0];
    wr_addr = best_slot;
    wr_data = hit;
    start_scan = 1'b0;
    scan_sel = SC_FIND;
    push = 1'b0;
    push_data = '0;
    rep_status_n = rep_status;
    rep_reason_n = rep_reason;
    rep_rem_n = rep_remaining;
    unique case (state)
      S_IDLE: if (in_valid) state_next = S_CHECK;
      S_CHECK: begin
        priority if (cmd.order_id == 0) begin
          rep_status_n = ST_REJECTED; rep_reason_n = RS_ID; rep_rem_n = '0;
          state_next = S_REPORT;
        end else if ((cmd.opcode == OP_LIMIT || cmd.opcode == OP_MARKET) &&
                     cmd.time_in_force == TIF_BAD) begin
          rep_status_n = ST_REJECTED; rep_reason_n = RS_INVALID; rep_rem_n = '0;
          state_next = S_REPORT;
        end else if ((cmd.opcode == OP_LIMIT || cmd.opcode == OP_MARKET) &&
                     cmd.quantity == 0) begin
          rep_status_n = ST_REJECTED; rep_reason_n = RS_QTY; rep_rem_n = '0;
          state_next = S_REPORT;
        end else if (cmd.opcode == OP_LIMIT && cmd.price <= 0) begin
          rep_status_n = ST_REJECTED; rep_reason_n = RS_PRICE; rep_rem_n = '0;
          state_next = S_REPORT;
        end else if (cmd.opcode == OP_MODIFY && cmd.price <= 0 && cmd.quantity == 0) begin
          rep_status_n = ST_REJECTED; rep_reason_n = RS_NOCHANGE; rep_rem_n = '0;
          state_next = S_REPORT;
        end else if (cmd.opcode == OP_MODIFY && cmd.price < 0) begin
          rep_status_n = ST_REJECTED; rep_reason_n = RS_PRICE; rep_rem_n = '0;
          state_next = S_REPORT;
        end else begin
          start_scan = 1'b1; scan_sel = SC_FIND; state_next = S_SCAN_RD;
        end
      end
      S_SCAN_RD: begin
        req.rd = 1'b1;
        state_next = S_SCAN;
      end
      S_SCAN: begin
        req.rd = 1'b1;
        if (scan_done) state_next = S_DECIDE;
      end
      S_DECIDE: begin
        unique case (scan)
          SC_FIND: begin
            priority if (cmd.opcode == OP_CANCEL) begin
              if (!found) begin
                rep_status_n = ST_REJECTED; rep_reason_n = RS_NOTFOUND; rep_rem_n = '0;
              end else begin
                rep_status_n = ST_CANCELLED; rep_reason_n = RS_NONE;
                rep_rem_n = hit.quantity;
                req.clr_valid = 1'b1; wr_addr = found_slot;
              end
              state_next = S_REPORT;
            end else if (cmd.opcode == OP_MODIFY) begin
              if (!found) begin
                rep_status_n = ST_REJECTED; rep_reason_n = RS_NOTFOUND; rep_rem_n = '0;
                state_next = S_REPORT;
              end else if (!chg) begin
                rep_status_n = ST_REJECTED; rep_reason_n = RS_NOCHANGE; rep_rem_n = '0;
                state_next = S_REPORT;
              end else begin
                req.clr_valid = 1'b1; wr_addr = found_slot;
                start_scan = 1'b1; scan_sel = SC_CROSS; state_next = S_SCAN_RD;
              end
            end else if (found) begin
              rep_status_n = ST_REJECTED; rep_reason_n = RS_DUPLICATE; rep_rem_n = '0;
              state_next = S_REPORT;
            end else begin
              start_scan = 1'b1; scan_sel = SC_MATCH; state_next = S_SCAN_RD;
            end
          end
          SC_MATCH: begin
            priority if (mkt && !fok_checked && !any_opp && filled == 0) begin
              rep_status_n = ST_REJECTED; rep_reason_n = RS_LIQUIDITY;
              rep_rem_n = qty; state_next = S_REPORT;
            end else if (tif == TIF_FOK && !fok_checked &&
                         elig_sum < {1'b0, qty}) begin
              rep_status_n = ST_REJECTED; rep_reason_n = RS_FOK;
              rep_rem_n = qty; state_next = S_REPORT;
            end else if (qty != 0 && best_ok) begin
              state_next = S_TRADE_RD;
            end else begin
              // matching over
              rep_rem_n = qty;
              rep_reason_n = RS_NONE;
              priority if (mkt) begin
                if (tif == TIF_FOK || qty == 0) rep_status_n = ST_FILLED;
                else if (filled != 0) rep_status_n = ST_PARTIAL;
                else begin
                  rep_status_n = ST_CANCELLED; rep_reason_n = RS_LIQUIDITY;
                end
                state_next = S_REPORT;
              end else if (tif == TIF_FOK || qty == 0) begin
                rep_status_n = mod_st(is_mod, ST_FILLED);
                state_next = S_REPORT;
              end else if (tif == TIF_IOC) begin
                rep_status_n = filled == 0 ? ST_CANCELLED :
                               (qty != 0 ? ST_PARTIAL : ST_FILLED);
                state_next = S_REPORT;
              end else begin
                start_scan = 1'b1; scan_sel = SC_CROSS; state_next = S_SCAN_RD;
              end
            end
          end
          default: begin
            // cross check: on a modify before matching, else after a GTC match
            if (is_mod && filled == 0 && !fok_checked) begin
              if (crosses) begin
                start_scan = 1'b1; scan_sel = SC_MATCH; state_next = S_SCAN_RD;
              end else begin
                state_next = S_REST;
              end
            end else if (crosses) begin
              rep_rem_n = qty; rep_reason_n = RS_STP;
              rep_status_n = mod_st(is_mod, filled != 0 ? ST_PARTIAL : ST_REJECTED);
              state_next = S_REPORT;
            end else begin
              state_next = S_REST;
            end
          end
        endcase
      end
      S_TRADE_RD: begin
        req.rd = 1'b1; rd_addr = best_slot; state_next = S_TRADE_WAIT;
      end
      S_TRADE_WAIT: state_next = S_TRADE_OUT;
      S_TRADE_OUT: begin
        if (!full) begin
          push = 1'b1;
          push_data.record_kind = KIND_TRADE;
          push_data.report_order_id = oid;
          push_data.other_order_id = hit.order_id;
          push_data.other_client_id = hit.client;
          push_data.trade_price = hit.price;
          push_data.trade_quantity = fill_q;
          push_data.trade_number = trade_counter + 1'b1;
          push_data.status = ST_RESTING;
          push_data.reject_reason = RS_NONE;
          wr_addr = best_slot;
          wr_data = hit;
          wr_data.quantity = hit.quantity - fill_q;
          req.wr = 1'b1;
          if (hit.quantity == fill_q) req.clr_valid = 1'b1;
          start_scan = 1'b1; scan_sel = SC_MATCH; state_next = S_SCAN_RD;
        end
      end
      S_REST: begin
        rep_rem_n = qty; rep_reason_n = RS_NONE;
        if (!free_ok) begin
          rep_status_n = ST_REJECTED; rep_reason_n = RS_FULL;
        end else begin
          req.wr = 1'b1; req.set_valid = 1'b1; wr_addr = free_slot;
          wr_data.order_id = oid; wr_data.client = cli; wr_data.side = sd;
          wr_data.price = px[30:0]; wr_data.quantity = qty;
          wr_data.arrival_seq = arrival_counter;
          rep_status_n = is_mod ? (filled != 0 ? ST_MODIFIED : ST_MODIFIED)
                                : (filled != 0 ? ST_PARTIAL : ST_RESTING);
        end
        state_next = S_REPORT;
      end
      S_REPORT: begin
        if (!full) begin
          push = 1'b1;
          push_data.record_kind = KIND_REPORT;
          push_data.report_order_id = oid;
          push_data.status = rep_status;
          push_data.reject_reason = rep_reason;
          push_data.filled_quantity = (rep_status == ST_REJECTED && rep_reason != RS_STP &&
                                       rep_reason != RS_FULL) ? 32'd0 : filled;
          push_data.remaining_quantity = rep_remaining;
          push_data.last = 1'b1;
          state_next = S_DONE;
        end
      end
      S_DONE: state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

endmodule
